### hdl/dcstseq_pkg.sv
`timescale 1ns / 1ps

package dcstseq_pkg;

    localparam int unsigned STATE_W    = 4;
    localparam int unsigned WAIT_W     = 11;
    localparam int unsigned FAULT_W    = 6;
    localparam int unsigned SWITCH_W   = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [STATE_W-1:0] LAST_STATE = 4'd8;
    localparam logic [STATE_W-1:0] LEAD_SPLIT = 4'd4;
    localparam logic [WAIT_W-1:0]  WAIT_MAX   = 11'h7FF;

    localparam logic [FAULT_W-1:0] FAULT_SEQUENCE = 6'h01;
    localparam logic [FAULT_W-1:0] FAULT_FEEDBACK = 6'h20;

    localparam logic [7:0] ADVANCE_TICKS_RST  = 8'd20;
    localparam logic [9:0] MISMATCH_TICKS_RST = 10'd200;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_SIDE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_TICKS = 2'd2;

    typedef enum logic [1:0] {
        DRV_OFF  = 2'd0,
        DRV_ON   = 2'd1,
        DRV_KEEP = 2'd2
    } drive_t;

    typedef struct packed {
        logic [STATE_W-1:0]  partner_state;
        logic                partner_ready;
        logic                pulse_feedback;
        logic [SWITCH_W-1:0] switch_inputs;
    } in_item_t;

    typedef struct packed {
        logic [STATE_W-1:0] sequence_now;
        logic               pulse_drive;
        logic [FAULT_W-1:0] fault_bits;
    } out_item_t;

    // pulse drive per state, master and slave tables
    function automatic drive_t drive_code(input logic master, input logic [STATE_W-1:0] s);
        drive_t d;
        d = DRV_ON;
        if (master) begin
            case (s)
                4'd2:                 d = DRV_KEEP;
                4'd5, 4'd6, 4'd7:     d = DRV_OFF;
                default:              d = DRV_ON;
            endcase
        end else begin
            case (s)
                4'd1, 4'd2, 4'd3:     d = DRV_OFF;
                4'd6:                 d = DRV_KEEP;
                default:              d = DRV_ON;
            endcase
        end
        return d;
    endfunction

    // partner state a follower waits for
    function automatic logic [STATE_W-1:0] expected_partner(input logic master,
                                                            input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] e;
        if (s == LAST_STATE) begin
            e = 4'd1;
        end else if (master && s == 4'd5) begin
            e = 4'd7;
        end else if (!master && s == 4'd1) begin
            e = 4'd3;
        end else begin
            e = s + 4'd1;
        end
        return e;
    endfunction

    function automatic logic [STATE_W-1:0] next_state(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] n;
        n = (s >= LAST_STATE) ? 4'd1 : s + 4'd1;
        return n;
    endfunction

endpackage

### hdl/dual_channel_switch_test_sequencer.sv
`timescale 1ns / 1ps

// dual channel switch test sequencer
//
// input channel (s_valid / s_ready / s_data): one item per control tick with the
// partner's sequence state and ready flag, the sampled pulse feedback and the
// four safety switch levels. result channel (m_valid / m_ready / m_data): one
// item per input item with the sequence state, pulse drive and sticky faults
// after that tick. configuration: cfg_wr_en, cfg_index, cfg_wdata write
// master_side, advance_ticks and mismatch_ticks; write only while the block is
// idle.
//
// an accepted item lands in the input register at the accepting edge and passes
// through the tick logic into the result register, from which it is taken.
// throughput is one item per cycle, set by the state update loop, while the
// receiver takes each result.
// reset (aresetn low, synchronous) empties both registers, returns to state 0
// with the pulse on, clears all faults and loads the register defaults.
// when the receiver stalls the result register holds; the input register still
// takes one more item, then s_ready drops until the result is taken.
module dual_channel_switch_test_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dcstseq_pkg::in_item_t         s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dcstseq_pkg::out_item_t        m_data,
    input  logic                          cfg_wr_en,
    input  logic [dcstseq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dcstseq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import dcstseq_pkg::*;

    // configuration registers
    logic       master_side_reg;
    logic [7:0] advance_ticks_reg;
    logic [9:0] mismatch_ticks_reg;

    // sequencer state
    logic [STATE_W-1:0] seq_state_reg, seq_state_next;
    logic [WAIT_W-1:0]  wait_count_reg, wait_count_next;
    logic               pulse_level_reg, pulse_level_next;
    logic [FAULT_W-1:0] faults_reg, faults_next;

    // pipeline registers
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic out_load;
    logic in_load;

    // the tick stage moves whenever the result register is free or being taken
    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_side_reg    <= 1'b1;
            advance_ticks_reg  <= ADVANCE_TICKS_RST;
            mismatch_ticks_reg <= MISMATCH_TICKS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MASTER_SIDE:    master_side_reg    <= cfg_wdata[0];
                CFG_ADVANCE_TICKS:  advance_ticks_reg  <= cfg_wdata[7:0];
                CFG_MISMATCH_TICKS: mismatch_ticks_reg <= cfg_wdata;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // per-tick sequencer logic
    logic               lead;
    logic               ready;
    logic               fb;
    drive_t             drv;
    logic [WAIT_W-1:0]  wait_bumped;
    logic [STATE_W-1:0] s;

    always_comb begin
        s     = seq_state_reg;
        ready = in_data_reg.partner_ready;
        fb    = in_data_reg.pulse_feedback;
        drv   = drive_code(master_side_reg, s);
        lead  = master_side_reg ? (s <= LEAD_SPLIT) : (s > LEAD_SPLIT);

        // saturating count; compares use the value before the bump
        wait_bumped = (wait_count_reg < WAIT_MAX) ? wait_count_reg + 11'd1 : wait_count_reg;

        seq_state_next   = seq_state_reg;
        wait_count_next  = wait_count_reg;
        pulse_level_next = pulse_level_reg;
        faults_next      = faults_reg;

        if (ready && s <= LAST_STATE) begin
            if (drv == DRV_OFF) begin
                pulse_level_next = 1'b0;
            end else if (drv == DRV_ON) begin
                pulse_level_next = 1'b1;
            end

            if (lead) begin
                if (s == 4'd2 || s == 4'd6) begin
                    // pulse-off test: switches that still read high are faulty
                    if (fb) begin
                        faults_next = faults_reg | {1'b0, in_data_reg.switch_inputs, 1'b0};
                    end else begin
                        faults_next = faults_reg | FAULT_FEEDBACK;
                    end
                    pulse_level_next = 1'b1;
                    seq_state_next   = s + 4'd1;
                    wait_count_next  = '0;
                end else if (wait_count_reg > {3'b000, advance_ticks_reg}) begin
                    seq_state_next  = next_state(s);
                    wait_count_next = '0;
                    if ((s == 4'd1 || s == 4'd5) && fb) begin
                        faults_next = faults_reg | FAULT_FEEDBACK;
                    end
                end else begin
                    wait_count_next = wait_bumped;
                end
            end else begin
                if (in_data_reg.partner_state == expected_partner(master_side_reg, s)) begin
                    seq_state_next  = next_state(s);
                    wait_count_next = '0;
                end else if (wait_count_reg > {1'b0, mismatch_ticks_reg}) begin
                    // partner never agreed: restart the sequence
                    faults_next     = faults_reg | FAULT_SEQUENCE;
                    wait_count_next = '0;
                    seq_state_next  = '0;
                end else begin
                    wait_count_next = wait_bumped;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            seq_state_reg   <= '0;
            wait_count_reg  <= '0;
            pulse_level_reg <= 1'b1;
            faults_reg      <= '0;
        end else begin
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end

            if (out_load) begin
                out_valid_reg   <= 1'b1;
                seq_state_reg   <= seq_state_next;
                wait_count_reg  <= wait_count_next;
                pulse_level_reg <= pulse_level_next;
                faults_reg      <= faults_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_data_reg <= s_data;
        end
        if (out_load) begin
            out_data_reg.sequence_now <= seq_state_next;
            out_data_reg.pulse_drive  <= pulse_level_next;
            out_data_reg.fault_bits   <= faults_next;
        end
    end

endmodule

### hdl/dcstseq_checker.sv
`timescale 1ns / 1ps

module dcstseq_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_valid,
    input logic                   m_ready,
    input dcstseq_pkg::out_item_t m_data
);
    import dcstseq_pkg::*;

    logic               seen_reg;
    logic [STATE_W-1:0] last_seq_reg;
    logic [FAULT_W-1:0] last_faults_reg;

    // remember the last delivered item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg        <= 1'b0;
            last_seq_reg    <= '0;
            last_faults_reg <= '0;
        end else if (m_valid && m_ready) begin
            seen_reg        <= 1'b1;
            last_seq_reg    <= m_data.sequence_now;
            last_faults_reg <= m_data.fault_bits;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_seq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.sequence_now <= LAST_STATE)
        else $error("sequence state out of range");

    // faults never clear between items
    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.fault_bits & last_faults_reg) == last_faults_reg)
        else $error("sticky fault cleared");

    // a fall back to state 0 comes only with a sequence fault
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && seen_reg && last_seq_reg != 4'd0 && m_data.sequence_now == 4'd0
        |-> m_data.fault_bits[0])
        else $error("sequence restart without fault");

endmodule

bind dual_channel_switch_test_sequencer dcstseq_checker u_dcstseq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
